>>> src/fractional_delay_line_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractional delay line
// Shared wrappers so that every concurrent check reads the same way.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH

// Check that is switched off while reset is held.
`define FDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also covers the reset cycles themselves.
`define FDL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants and types of the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  // Depth must be a power of two: the read position wraps by truncation.
  localparam int DEPTH       = 4096;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_W    = 16;
  localparam int DELAY_W     = 20;
  localparam int POS_W       = ADDR_W + FRAC_BITS;
  localparam int IN_FIELDS_W = SAMPLE_W + DELAY_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // Control travelling alongside the registered read data.
  typedef struct packed {
    logic                 valid;
    logic                 a_ok;   // first tap has been written since reset
    logic                 b_ok;   // second tap has been written since reset
    logic [FRAC_BITS-1:0] frac;
  } s1_ctrl_t;

endpackage

>>> src/fdl_store.sv
// ----------------------------------------------------------------------------
// fdl_store
// Sample memory with write pointer, tap addressing and fill tracking.
// ----------------------------------------------------------------------------
`include "fractional_delay_line_macros.svh"

module fdl_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0]  sample,
  input  logic        [fdl_pkg::DELAY_W-1:0]   delay,
  input  logic                                 s1_adv,
  output fdl_pkg::s1_ctrl_t                    s1_r,
  output logic signed [fdl_pkg::SAMPLE_W-1:0]  rd_a_r,
  output logic signed [fdl_pkg::SAMPLE_W-1:0]  rd_b_r
);

  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_mem [fdl_pkg::DEPTH];

  logic [fdl_pkg::ADDR_W-1:0] wr_idx_r;
  logic [fdl_pkg::ADDR_W-1:0] wr_idx_nxt;
  logic                       wrapped_r;
  logic                       wrapped_nxt;
  fdl_pkg::s1_ctrl_t          s1_nxt;

  logic [fdl_pkg::POS_W-1:0]  pos;
  logic [fdl_pkg::ADDR_W-1:0] tap0;
  logic [fdl_pkg::ADDR_W-1:0] tap1;

  // Read position in fixed point; the subtraction wraps modulo the store.
  assign pos  = fdl_pkg::POS_W'({wr_idx_r, {fdl_pkg::FRAC_BITS{1'b0}}})
              - fdl_pkg::POS_W'(delay);
  assign tap0 = pos[fdl_pkg::POS_W-1:fdl_pkg::FRAC_BITS];
  assign tap1 = tap0 + fdl_pkg::ADDR_W'(1);

  // Entries are written in index order from zero, so an entry holds real
  // data once the pointer has passed it or has wrapped at least once.
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    wrapped_nxt = wrapped_r;
    s1_nxt      = s1_r;
    if (accept) begin
      wr_idx_nxt  = wr_idx_r + fdl_pkg::ADDR_W'(1);
      wrapped_nxt = wrapped_r | (&wr_idx_r);
      s1_nxt.valid = 1'b1;
      s1_nxt.a_ok  = wrapped_r | (tap0 < wr_idx_r);
      s1_nxt.b_ok  = wrapped_r | (tap1 < wr_idx_r);
      s1_nxt.frac  = pos[fdl_pkg::FRAC_BITS-1:0];
    end else if (s1_adv) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      wrapped_r <= 1'b0;
      s1_r      <= '0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      wrapped_r <= wrapped_nxt;
      s1_r      <= s1_nxt;
    end
  end

  // Both taps are read at the edge that writes the new sample, so they see
  // the contents from before this beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a_r               <= sample_mem[tap0];
      rd_b_r               <= sample_mem[tap1];
      sample_mem[wr_idx_r] <= sample;
    end
  end

  `FDL_ASSERT_RST(a_rst_clears, !rst_n |=> (wr_idx_r == '0) && !wrapped_r && !s1_r.valid,
    "write pointer or pipeline not cleared by reset")
  `FDL_ASSERT(a_ptr_step, accept |=> wr_idx_r == $past(wr_idx_r) + fdl_pkg::ADDR_W'(1),
    "write pointer did not advance on an accepted beat")
  `FDL_ASSERT(a_ptr_hold, !accept |=> $stable(wr_idx_r),
    "write pointer moved without an accepted beat")
  `FDL_ASSERT(a_rd_hold, (s1_r.valid && !s1_adv && !accept) |=> $stable(rd_a_r) && $stable(rd_b_r),
    "read data changed while waiting for the output stage")

endmodule

>>> src/fdl_interp.sv
// ----------------------------------------------------------------------------
// fdl_interp
// Linear interpolation between the two taps and the output register.
// ----------------------------------------------------------------------------
module fdl_interp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fdl_pkg::s1_ctrl_t                    s1,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0]  rd_a,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0]  rd_b,
  output logic                                 s1_adv,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic        [fdl_pkg::OUT_TDATA_W-1:0] out_tdata  // [15:0] sample_out
);

  localparam int DIFF_W = fdl_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + fdl_pkg::FRAC_BITS + 1;

  logic signed [fdl_pkg::SAMPLE_W-1:0] a_v;
  logic signed [fdl_pkg::SAMPLE_W-1:0] b_v;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [PROD_W-1:0]            prod;
  logic signed [PROD_W-1:0]            rounded;
  logic signed [DIFF_W-1:0]            result;

  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic signed [fdl_pkg::SAMPLE_W-1:0] out_data_r;

  // Entries not yet written since reset read as zero.
  assign a_v = s1.a_ok ? rd_a : '0;
  assign b_v = s1.b_ok ? rd_b : '0;

  // a*(1-f) + b*f rounded half up equals a + floor(((b-a)*f + half) / one).
  assign diff    = DIFF_W'(b_v) - DIFF_W'(a_v);
  assign prod    = PROD_W'(diff) * $signed({1'b0, s1.frac});
  assign rounded = (prod + PROD_W'(1 << (fdl_pkg::FRAC_BITS - 1))) >>> fdl_pkg::FRAC_BITS;
  assign result  = DIFF_W'(a_v) + rounded[DIFF_W-1:0];

  assign s1_adv = s1.valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result[fdl_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fdl_pkg::OUT_TDATA_W'(unsigned'(out_data_r));

endmodule

>>> src/fractional_delay_line.sv
// ----------------------------------------------------------------------------
// fractional_delay_line
// Circular sample store read at a fractional delay with linear interpolation.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle as long as the output side keeps
// up. Each result passes through the registered read stage and then the
// output register; a waiting result does not stop the next input beat, which
// is held in the read stage. The sample memory serves both tap reads and the
// write of the new sample in the same cycle, with the read data registered.
// The store needs no clearing pass after reset: entries are filled in order
// from index zero, and an entry that has not been written since reset reads
// as zero. The delay is in samples with eight fraction bits and is taken
// modulo the store depth of 4096 samples.
module fractional_delay_line (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fdl_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] sample_in, [35:16] delay_q8
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fdl_pkg::OUT_TDATA_W-1:0]    out_tdata   // [15:0] sample_out
);

  logic                                accept;
  logic                                s1_adv;
  fdl_pkg::s1_ctrl_t                   s1;
  logic signed [fdl_pkg::SAMPLE_W-1:0] rd_a;
  logic signed [fdl_pkg::SAMPLE_W-1:0] rd_b;
  logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in;
  logic        [fdl_pkg::DELAY_W-1:0]  delay_q8;

  assign sample_in = $signed(in_tdata[fdl_pkg::SAMPLE_W-1:0]);
  assign delay_q8  = in_tdata[fdl_pkg::IN_FIELDS_W-1:fdl_pkg::SAMPLE_W];

  assign in_tready = !s1.valid || s1_adv;
  assign accept    = in_tvalid && in_tready;

  fdl_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (sample_in),
    .delay  (delay_q8),
    .s1_adv (s1_adv),
    .s1_r   (s1),
    .rd_a_r (rd_a),
    .rd_b_r (rd_b)
  );

  fdl_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .s1_adv     (s1_adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional delay line testbench
// Streams audio samples with fractional delays into the block and checks
// every output beat against a bit-exact model of the circular store and its
// linear interpolation. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------

class delay_line_scoreboard;
  logic signed [fdl_pkg::SAMPLE_W-1:0] history [fdl_pkg::DEPTH];
  logic [fdl_pkg::ADDR_W-1:0]          wr_idx;
  logic [fdl_pkg::SAMPLE_W-1:0]        expected_q [$];
  int                                  mismatches;

  function new();
    foreach (history[i]) history[i] = '0;
    wr_idx     = '0;
    mismatches = 0;
  endfunction

  // Works out the interpolated sample for an accepted input beat, then stores
  // the new sample exactly as the block does: both taps are read first.
  function void note_input(logic signed [fdl_pkg::SAMPLE_W-1:0] sample,
                           logic [fdl_pkg::DELAY_W-1:0] delay);
    logic [fdl_pkg::POS_W-1:0]     rd_pos;
    logic [fdl_pkg::ADDR_W-1:0]    tap_a;
    logic [fdl_pkg::ADDR_W-1:0]    tap_b;
    logic [fdl_pkg::FRAC_BITS-1:0] frac;
    int                            a;
    int                            b;
    int                            fw;
    int                            acc;
    int                            interp;
    rd_pos = {wr_idx, {fdl_pkg::FRAC_BITS{1'b0}}} - delay[fdl_pkg::POS_W-1:0];
    tap_a  = rd_pos[fdl_pkg::POS_W-1:fdl_pkg::FRAC_BITS];
    tap_b  = tap_a + 1'b1;
    frac   = rd_pos[fdl_pkg::FRAC_BITS-1:0];
    a      = history[tap_a];
    b      = history[tap_b];
    fw     = frac;
    acc    = a * ((1 << fdl_pkg::FRAC_BITS) - fw) + b * fw
             + (1 << (fdl_pkg::FRAC_BITS - 1));
    // Arithmetic shift gives the floor, hence rounding half up overall.
    interp = acc >>> fdl_pkg::FRAC_BITS;
    expected_q.push_back(interp[fdl_pkg::SAMPLE_W-1:0]);
    history[wr_idx] = sample;
    wr_idx          = wr_idx + 1'b1;
  endfunction

  function void check_result(logic [fdl_pkg::SAMPLE_W-1:0] got);
    logic [fdl_pkg::SAMPLE_W-1:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Output beat %h arrived with no sample outstanding", got);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample_out mismatch: expected %h, got %h", want, got);
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;

  localparam int RANDOM_BEATS = 1900;
  localparam int CALM_BEATS   = 200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 10;
  localparam int INT_W        = fdl_pkg::DELAY_W - fdl_pkg::FRAC_BITS;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [fdl_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fdl_pkg::OUT_TDATA_W-1:0] out_tdata;

  delay_line_scoreboard sb = new();

  int in_gap_pct     = 0;
  int out_stall_pct  = 0;
  int out_stall_left = 0;
  int cycle_count    = 0;

  fractional_delay_line DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Values read here are those from before the edge, as every driver uses
  // nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tdata[fdl_pkg::SAMPLE_W-1:0],
                    in_tdata[fdl_pkg::SAMPLE_W +: fdl_pkg::DELAY_W]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[fdl_pkg::SAMPLE_W-1:0]);
  end

  // Receiver back-pressure: out_tready is pulled low in bursts that start at random.
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      out_tready     <= 1'b0;
    end else if ($urandom_range(99) < out_stall_pct) begin
      out_stall_left <= $urandom_range(12);
      out_tready     <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Presents one beat and returns at the edge where it is taken.
  task automatic send_beat(input logic [fdl_pkg::SAMPLE_W-1:0] sample,
                           input logic [fdl_pkg::DELAY_W-1:0] delay);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(fdl_pkg::IN_TDATA_W - fdl_pkg::IN_FIELDS_W){1'b0}}, delay, sample};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [fdl_pkg::DELAY_W-1:0] pick_delay();
    logic [fdl_pkg::DELAY_W-1:0] d;
    d = fdl_pkg::DELAY_W'($urandom());
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        d[fdl_pkg::DELAY_W-1:fdl_pkg::FRAC_BITS] = INT_W'($urandom_range(1, 32));
      end
      5, 6: begin
        d[fdl_pkg::DELAY_W-1:fdl_pkg::FRAC_BITS] =
          INT_W'($urandom_range(1, fdl_pkg::DEPTH - 2));
      end
      7:             ;  // any value of the field
      8:             d[fdl_pkg::DELAY_W-1:fdl_pkg::FRAC_BITS] = '0;
      default: begin
        d[fdl_pkg::DELAY_W-1:fdl_pkg::FRAC_BITS] =
          INT_W'($urandom_range(fdl_pkg::DEPTH - 2, fdl_pkg::DEPTH - 1));
      end
    endcase
    if ($urandom_range(19) == 0)
      d[fdl_pkg::FRAC_BITS-1:0] = '0;
    return d;
  endfunction

  function automatic logic [fdl_pkg::SAMPLE_W-1:0] pick_sample();
    logic [fdl_pkg::SAMPLE_W-1:0] s;
    s = fdl_pkg::SAMPLE_W'($urandom());
    case ($urandom_range(19))
      0:       s = 16'h7FFF;
      1:       s = 16'h8000;
      2:       s = 16'hFFFF;
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sample extremes, zero delay, integer part zero, half-way
    // fractions, the largest delay code and delays that wrap round the store.
    send_beat(16'h7FFF, 20'h00000);
    send_beat(16'h8000, 20'h00100);
    send_beat(16'hFFFF, 20'h00180);
    send_beat(16'h0001, 20'h00080);
    send_beat(16'h5555, 20'h000FF);
    send_beat(16'hAAAA, 20'h00001);
    send_beat(16'h0064, 20'hFFFFF);
    send_beat(16'hFF9C, 20'hFFE00);
    send_beat(16'h0007, 20'h80000);
    send_beat(16'hFFF9, 20'h7FFFF);
    send_beat(16'h7FFF, 20'h00101);
    send_beat(16'h8000, 20'h001FF);
    send_beat(16'h0000, 20'h0FF00);
    send_beat(16'h7F00, 20'h00300);
    send_beat(16'h80FF, 20'h00280);
    send_beat(16'h3039, 20'h0FFFF);
    send_beat(16'hCFC7, 20'hF0001);
    send_beat(16'h7FFF, 20'h00000);
    send_beat(16'h8000, 20'h00400);
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - CALM_BEATS) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else if (n < RANDOM_BEATS - CALM_BEATS && n % 128 == 0) begin
        in_gap_pct    = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 35);
        out_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 35);
      end
      if (n == RANDOM_BEATS / 2)
        drain();
      send_beat(pick_sample(), pick_delay());
      if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
